### src/dqpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared constants, register codes and the pipeline control bundle for the
// d/q PI current loop.
// ----------------------------------------------------------------------------
package dqpi_pkg;

	localparam int SAMPLE_W_DEF = 16;
	localparam int ACC_W_DEF    = 32;

	// gain formats: kp is Q8.16, ki per tick is Q4.20
	localparam int GAIN_W  = 24;
	localparam int KP_FRAC = 16;
	localparam int KI_FRAC = 20;

	localparam int CFG_IDX_W = 3;

	localparam logic [GAIN_W-1:0] KP_RST = GAIN_W'(32768);
	localparam logic [GAIN_W-1:0] KI_RST = GAIN_W'(5243);
	localparam int                LIM_RST = 3072;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_D_KP   = 3'd0,
		REG_D_KI   = 3'd1,
		REG_D_ILIM = 3'd2,
		REG_D_OLIM = 3'd3,
		REG_Q_KP   = 3'd4,
		REG_Q_KI   = 3'd5,
		REG_Q_ILIM = 3'd6,
		REG_Q_OLIM = 3'd7
	} dqpi_reg_t;

	// load strobes for each pipeline stage plus the clear flag of the stage 2 item
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
		logic clr_s2;
	} dqpi_ctl_t;

endpackage

### src/dq_pi_current_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pi_current_loop
// Two-axis d/q PI current controller with clamping anti-windup; the d and q
// lanes run side by side and their results merge into one output register.
// ----------------------------------------------------------------------------
// path: an accepted item passes stage 1, stage 2, stage 3 and the output register
// throughput: one item per cycle unless out_ready stalls the output; the integrator
//   updates in a loop on its own register in stage 3 of each lane, the gain multiplies sit in stage 2
// reset: pipeline empty, both integrators zero, gains and limits to defaults
// config writes are registered, cfg_ready is always high
module dq_pi_current_loop #(
	parameter int SAMPLE_WIDTH = dqpi_pkg::SAMPLE_W_DEF,
	parameter int ACC_WIDTH    = dqpi_pkg::ACC_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dqpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dqpi_pkg::GAIN_W-1:0]         cfg_data,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic signed [SAMPLE_WIDTH-1:0]      d_target,
	input  logic signed [SAMPLE_WIDTH-1:0]      q_target,
	input  logic signed [SAMPLE_WIDTH-1:0]      d_measured,
	input  logic signed [SAMPLE_WIDTH-1:0]      q_measured,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      d_voltage,
	output logic signed [SAMPLE_WIDTH-1:0]      q_voltage,
	output logic                                d_saturated,
	output logic                                q_saturated,
	output logic signed [SAMPLE_WIDTH-1:0]      d_integrator_out,
	output logic signed [SAMPLE_WIDTH-1:0]      q_integrator_out
);
	import dqpi_pkg::*;

	localparam int LW = SAMPLE_WIDTH - 1;

	dqpi_ctl_t ctl;

	logic [GAIN_W-1:0] d_kp_q, d_ki_q, q_kp_q, q_ki_q;
	logic [LW-1:0]     d_ilim_q, d_olim_q, q_ilim_q, q_olim_q;

	logic signed [SAMPLE_WIDTH-1:0] d_volt, q_volt, d_integ, q_integ;
	logic                           d_sat, q_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_kp_q   <= KP_RST;
			d_ki_q   <= KI_RST;
			d_ilim_q <= LW'(LIM_RST);
			d_olim_q <= LW'(LIM_RST);
			q_kp_q   <= KP_RST;
			q_ki_q   <= KI_RST;
			q_ilim_q <= LW'(LIM_RST);
			q_olim_q <= LW'(LIM_RST);
		end else if (cfg_valid) begin
			unique case (dqpi_reg_t'(cfg_index))
				REG_D_KP: begin
					d_kp_q <= cfg_data;
				end
				REG_D_KI: begin
					d_ki_q <= cfg_data;
				end
				REG_D_ILIM: begin
					d_ilim_q <= cfg_data[LW-1:0];
				end
				REG_D_OLIM: begin
					d_olim_q <= cfg_data[LW-1:0];
				end
				REG_Q_KP: begin
					q_kp_q <= cfg_data;
				end
				REG_Q_KI: begin
					q_ki_q <= cfg_data;
				end
				REG_Q_ILIM: begin
					q_ilim_q <= cfg_data[LW-1:0];
				end
				REG_Q_OLIM: begin
					q_olim_q <= cfg_data[LW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	dqpi_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	dqpi_lane #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_WIDTH    (ACC_WIDTH)
	) u_lane_d (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.prop_gain  (d_kp_q),
		.int_gain   (d_ki_q),
		.int_limit  (d_ilim_q),
		.volt_limit (d_olim_q),
		.target     (d_target),
		.measured   (d_measured),
		.voltage    (d_volt),
		.saturated  (d_sat),
		.integrator (d_integ)
	);

	dqpi_lane #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_WIDTH    (ACC_WIDTH)
	) u_lane_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.prop_gain  (q_kp_q),
		.int_gain   (q_ki_q),
		.int_limit  (q_ilim_q),
		.volt_limit (q_olim_q),
		.target     (q_target),
		.measured   (q_measured),
		.voltage    (q_volt),
		.saturated  (q_sat),
		.integrator (q_integ)
	);

	// merge both lanes into the output item register
	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			d_voltage        <= d_volt;
			q_voltage        <= q_volt;
			d_saturated      <= d_sat;
			q_saturated      <= q_sat;
			d_integrator_out <= d_integ;
			q_integrator_out <= q_integ;
		end
	end

endmodule

### src/dqpi_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_pipe_ctrl
// Valid/ready chain of the four-stage pipeline; stages advance independently
// so bubbles collapse, and a waiting result stalls new items only once every
// stage holds an item.
// ----------------------------------------------------------------------------
module dqpi_pipe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dqpi_pkg::dqpi_ctl_t   ctl
);
	import dqpi_pkg::*;

	logic v_s1, v_s2, v_s3, out_valid_q;
	logic clr_s1, clr_s2;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_out = !out_valid_q || out_ready;
	assign rdy_s3  = !v_s3 || rdy_out;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign in_ready  = rdy_s1;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl.ld_s1  = in_valid && rdy_s1;
		ctl.ld_s2  = v_s1 && rdy_s2;
		ctl.ld_s3  = v_s2 && rdy_s3;
		ctl.ld_out = v_s3 && rdy_out;
		ctl.clr_s2 = clr_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			clr_s1      <= 1'b0;
			clr_s2      <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				out_valid_q <= v_s3;
			end
			if (ctl.ld_s1) begin
				clr_s1 <= action;
			end
			if (ctl.ld_s2) begin
				clr_s2 <= clr_s1;
			end
		end
	end

endmodule

### src/dqpi_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_lane
// One PI regulator axis: error, gain multiply, clamped integrator update,
// then proportional add, output clamp and truncation to the sample format.
// ----------------------------------------------------------------------------
module dqpi_lane #(
	parameter int SAMPLE_WIDTH = dqpi_pkg::SAMPLE_W_DEF,
	parameter int ACC_WIDTH    = dqpi_pkg::ACC_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dqpi_pkg::dqpi_ctl_t                 ctl,
	input  logic [dqpi_pkg::GAIN_W-1:0]         prop_gain,
	input  logic [dqpi_pkg::GAIN_W-1:0]         int_gain,
	input  logic [SAMPLE_WIDTH-2:0]             int_limit,
	input  logic [SAMPLE_WIDTH-2:0]             volt_limit,
	input  logic signed [SAMPLE_WIDTH-1:0]      target,
	input  logic signed [SAMPLE_WIDTH-1:0]      measured,
	output logic signed [SAMPLE_WIDTH-1:0]      voltage,
	output logic                                saturated,
	output logic signed [SAMPLE_WIDTH-1:0]      integrator
);
	import dqpi_pkg::*;

	localparam int S   = SAMPLE_WIDTH;
	localparam int A   = ACC_WIDTH;
	localparam int EW  = S + 1;
	localparam int PW  = S + GAIN_W + 1;
	localparam int LSH = A - S;

	// product scaling to the integrator format; negative means shift left
	localparam int KI_SH = KI_FRAC + S - A;
	localparam int KI_LS = (KI_SH < 0) ? -KI_SH : 0;
	localparam int KI_RS = (KI_SH > 0) ? KI_SH : 0;
	localparam int KI_TW = PW + KI_LS;
	localparam int IW    = PW - KI_SH;

	localparam int KP_SH = KP_FRAC + S - A;
	localparam int KP_LS = (KP_SH < 0) ? -KP_SH : 0;
	localparam int KP_RS = (KP_SH > 0) ? KP_SH : 0;
	localparam int KP_TW = PW + KP_LS;
	localparam int PRW   = PW - KP_SH;

	localparam int ISW = IW + 1;
	localparam int SSW = PRW + 1;

	logic signed [EW-1:0]    err_s1;
	logic signed [PW-1:0]    ki_prod, kp_prod;
	logic signed [KI_TW-1:0] ki_wide;
	logic signed [KP_TW-1:0] kp_wide;
	logic signed [IW-1:0]    inc_s2;
	logic signed [PRW-1:0]   prop_s2, prop_s3;
	logic signed [A-1:0]     integ_q, integ_nxt;
	logic signed [ISW-1:0]   isum, ilim_x;
	logic signed [SSW-1:0]   ssum, olim_x;
	logic signed [A-1:0]     vclamp, vshift, ishift;

	// stage 1: error
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			err_s1 <= EW'(target) - EW'(measured);
		end
	end

	// stage 2: gain products scaled to Q(S).(A-S)
	assign ki_prod = signed'(PW'({1'b0, int_gain})) * PW'(err_s1);
	assign kp_prod = signed'(PW'({1'b0, prop_gain})) * PW'(err_s1);
	assign ki_wide = (KI_TW'(ki_prod) <<< KI_LS) >>> KI_RS;
	assign kp_wide = (KP_TW'(kp_prod) <<< KP_LS) >>> KP_RS;

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			inc_s2  <= ki_wide[IW-1:0];
			prop_s2 <= kp_wide[PRW-1:0];
		end
	end

	// stage 3: integrator update with clamp, a recurrence through integ_q alone
	assign ilim_x = signed'(ISW'(int_limit)) <<< LSH;
	assign isum   = ISW'(integ_q) + ISW'(inc_s2);

	always_comb begin
		if (isum > ilim_x) begin
			integ_nxt = ilim_x[A-1:0];
		end else if (isum < -ilim_x) begin
			integ_nxt = A'(-ilim_x);
		end else begin
			integ_nxt = isum[A-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctl.ld_s3) begin
			integ_q <= ctl.clr_s2 ? '0 : integ_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			prop_s3 <= ctl.clr_s2 ? '0 : prop_s2;
		end
	end

	// output clamp, saturation flag from the exact sum
	assign olim_x = signed'(SSW'(volt_limit)) <<< LSH;
	assign ssum   = SSW'(integ_q) + SSW'(prop_s3);

	always_comb begin
		saturated = 1'b0;
		if (ssum > olim_x) begin
			vclamp    = olim_x[A-1:0];
			saturated = 1'b1;
		end else if (ssum < -olim_x) begin
			vclamp    = A'(-olim_x);
			saturated = 1'b1;
		end else begin
			vclamp = ssum[A-1:0];
		end
	end

	assign vshift     = vclamp >>> LSH;
	assign ishift     = integ_q >>> LSH;
	assign voltage    = vshift[S-1:0];
	assign integrator = ishift[S-1:0];

endmodule
